/* rtl/scbd_pkg.sv */
// scbd_pkg: shared types and constants of the string-control-byte record decoder
// used by scbd_ctrl, scbd_dp and scb_record_decoder; no dependencies

package scbd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int ACC_W   = 17;
    localparam int SEG_W   = 6;
    localparam int CNT_W   = 5;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = BYTE_W + 2 * LEN_W;

    // register reset and fixed values
    localparam logic [LEN_W-1:0]  LIMIT_RESET = 16'd4096;
    localparam logic [LEN_W-1:0]  LEN_SAT     = 16'hFFFF;
    localparam logic [ACC_W-1:0]  ACC_MAX     = 17'h1FFFF;
    localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h40;

    // control byte classes, by high nibble
    localparam logic [3:0] NIB_END       = 4'h0;
    localparam logic [3:0] NIB_ABORT     = 4'h4;
    localparam logic [3:0] NIB_BLANK_LO  = 4'h8;
    localparam logic [3:0] NIB_BLANK_HI  = 4'h9;
    localparam logic [3:0] NIB_REPEAT_LO = 4'hA;
    localparam logic [3:0] NIB_REPEAT_HI = 4'hB;
    localparam logic [3:0] NIB_COPY_LO   = 4'hC;
    localparam logic [3:0] NIB_COPY_HI   = 4'hF;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    // decoder phase within a record
    typedef enum logic [2:0] {
        PH_CTRL   = 3'b001,
        PH_REPEAT = 3'b010,
        PH_COPY   = 3'b100
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_data;
        logic emit_close;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_work;
        logic cnt_zero;
        logic cnt_one;
        logic close_pend;
        logic out_free;
    } sts_t;

endpackage

/* rtl/scb_record_decoder.sv */
// scb_record_decoder: top level of the string-control-byte record decoder
// instantiates scbd_ctrl and scbd_dp; depends on scbd_pkg
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = in_byte, s_tlast = in_last
//  m_        out  m_tvalid/m_tready  m_tdata = out_byte, rec_length, consumed;
//                                    m_tuser = kind, m_tlast = last
//  cfg_      in   cfg_we             cfg_wdata = out_limit
//
// a request is taken only while the sequencer is idle; a request that makes k results
// then sends them one by one through the single result register, and no other request
// is taken until its last result is sent; the last result of a request overlaps the next request
// reset (aresetn low, synchronous) clears record state and sets out_limit to 4096
// a stalled m_ side holds the result register and stops the sequencer

module scb_record_decoder
    import scbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,   // out_limit
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,     // [7:0] in_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,     // [7:0] out_byte, [23:8] rec_length,
                                            // [39:24] consumed
    output logic [KIND_W-1:0]  m_tuser,     // [1:0] kind
    output logic               m_tlast
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    scbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // decode and result path
    scbd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/scbd_ctrl.sv */
// scbd_ctrl: sequencer of the record decoder; takes one request, then drives
// its results out one per cycle while the result register is free; depends on scbd_pkg

module scbd_ctrl
    import scbd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // commands
    always_comb begin
        s_tready       = (state_reg == S_IDLE);
        cmd.accept     = s_tvalid && (state_reg == S_IDLE);
        cmd.emit_data  = (state_reg == S_EMIT) && sts.out_free && !sts.cnt_zero;
        cmd.emit_close = (state_reg == S_EMIT) && sts.out_free && sts.cnt_zero
                         && sts.close_pend;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && sts.has_work) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (cmd.emit_data && sts.cnt_one && !sts.close_pend) begin
                    state_next = S_IDLE;
                end else if (cmd.emit_close) begin
                    state_next = S_IDLE;
                end else if (sts.cnt_zero && !sts.close_pend) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // emitting always has something left to send
    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> (!sts.cnt_zero || sts.close_pend))
        else $error("emit state with no pending result");

    // the closing result is the final one of a request
    a_close_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_close |=> state_reg == S_IDLE)
        else $error("closing result did not end emission");

endmodule

/* rtl/scbd_dp.sv */
// scbd_dp: record state, control byte decode, length check and result register
// of the record decoder; depends on scbd_pkg

module scbd_dp
    import scbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    input  logic [BYTE_W-1:0]  s_tdata,
    input  logic               s_tlast,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]  m_tuser,
    output logic               m_tlast
);

    // configuration and record state
    logic [LEN_W-1:0]  limit_reg;
    phase_t            phase_reg, phase_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              supp_reg, supp_next;
    logic              err_reg, err_next;
    logic [ACC_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  bcnt_reg, bcnt_inc;

    // pending job of the current request
    logic [CNT_W-1:0]  cnt_reg, job_cnt;
    logic [BYTE_W-1:0] dbyte_reg, job_byte;
    logic              cpend_reg, job_close;
    logic              cok_reg, job_ok;
    logic [LEN_W-1:0]  clen_reg, job_len;
    logic [LEN_W-1:0]  ccons_reg;

    // result register
    logic              ovalid_reg;
    kind_t             okind_reg;
    logic [BYTE_W-1:0] obyte_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic [LEN_W-1:0]  ocons_reg;
    logic              olast_reg;

    // length accumulate
    logic [3:0]        nib;
    logic [SEG_W-1:0]  add_n;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  len_sat;
    logic              supp_new;

    assign nib      = s_tdata[7:4];
    assign add_n    = nib[2] ? s_tdata[5:0] : {1'b0, s_tdata[4:0]};
    assign sum      = {1'b0, len_reg} + {{(ACC_W + 1 - SEG_W){1'b0}}, add_n};
    assign len_sat  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    assign supp_new = len_sat > {1'b0, limit_reg};
    assign bcnt_inc = (bcnt_reg == LEN_SAT) ? bcnt_reg : bcnt_reg + 1'b1;

    // decode of one request
    always_comb begin
        phase_next = phase_reg;
        seg_next   = seg_reg;
        supp_next  = supp_reg;
        err_next   = err_reg;
        len_next   = len_reg;
        job_cnt    = '0;
        job_byte   = s_tdata;
        job_close  = 1'b0;
        job_ok     = 1'b0;
        case (phase_reg)
            PH_REPEAT: begin
                job_cnt    = supp_reg ? '0 : seg_reg[CNT_W-1:0];
                phase_next = PH_CTRL;
                seg_next   = '0;
            end
            PH_COPY: begin
                job_cnt  = supp_reg ? '0 : CNT_W'(1);
                seg_next = seg_reg - 1'b1;
                if (seg_next == '0) begin
                    phase_next = PH_CTRL;
                end
            end
            default: begin
                case (nib) inside
                    NIB_END: begin
                        job_close = 1'b1;
                        job_ok    = !err_reg;
                    end
                    NIB_ABORT: begin
                        job_close = 1'b1;
                    end
                    [NIB_BLANK_LO:NIB_BLANK_HI]: begin
                        len_next  = len_sat;
                        supp_next = supp_new;
                        err_next  = err_reg | supp_new;
                        job_cnt   = supp_new ? '0 : s_tdata[4:0];
                        job_byte  = BLANK_CHAR;
                    end
                    [NIB_REPEAT_LO:NIB_REPEAT_HI]: begin
                        len_next   = len_sat;
                        supp_next  = supp_new;
                        err_next   = err_reg | supp_new;
                        seg_next   = {1'b0, s_tdata[4:0]};
                        phase_next = PH_REPEAT;
                    end
                    [NIB_COPY_LO:NIB_COPY_HI]: begin
                        len_next   = len_sat;
                        supp_next  = supp_new;
                        err_next   = err_reg | supp_new;
                        seg_next   = s_tdata[5:0];
                        phase_next = (s_tdata[5:0] != '0) ? PH_COPY : PH_CTRL;
                    end
                    default: ;
                endcase
            end
        endcase
        // input ends before the record closed
        if (s_tlast && !job_close) begin
            job_close = 1'b1;
            job_ok    = 1'b0;
        end
        job_len = len_next[ACC_W-1] ? LEN_SAT : len_next[LEN_W-1:0];
    end

    // status
    always_comb begin
        sts.has_work   = (job_cnt != '0) || job_close;
        sts.cnt_zero   = (cnt_reg == '0);
        sts.cnt_one    = (cnt_reg == CNT_W'(1));
        sts.close_pend = cpend_reg;
        sts.out_free   = !ovalid_reg || m_tready;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // record state, cleared when a record closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CTRL;
            seg_reg   <= '0;
            supp_reg  <= 1'b0;
            err_reg   <= 1'b0;
            len_reg   <= '0;
            bcnt_reg  <= '0;
        end else if (cmd.accept) begin
            if (job_close) begin
                phase_reg <= PH_CTRL;
                seg_reg   <= '0;
                supp_reg  <= 1'b0;
                err_reg   <= 1'b0;
                len_reg   <= '0;
                bcnt_reg  <= '0;
            end else begin
                phase_reg <= phase_next;
                seg_reg   <= seg_next;
                supp_reg  <= supp_next;
                err_reg   <= err_next;
                len_reg   <= len_next;
                bcnt_reg  <= bcnt_inc;
            end
        end
    end

    // pending job control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            cpend_reg <= 1'b0;
        end else if (cmd.accept) begin
            cnt_reg   <= job_cnt;
            cpend_reg <= job_close;
        end else if (cmd.emit_data) begin
            cnt_reg <= cnt_reg - 1'b1;
        end else if (cmd.emit_close) begin
            cpend_reg <= 1'b0;
        end
    end

    // pending job payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dbyte_reg <= job_byte;
            cok_reg   <= job_ok;
            clen_reg  <= job_len;
            ccons_reg <= bcnt_inc;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit_data || cmd.emit_close) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_data) begin
            okind_reg <= KIND_DATA;
            obyte_reg <= dbyte_reg;
            olen_reg  <= '0;
            ocons_reg <= '0;
            olast_reg <= (cnt_reg == CNT_W'(1)) && !cpend_reg;
        end else if (cmd.emit_close) begin
            okind_reg <= cok_reg ? KIND_DONE : KIND_FAIL;
            obyte_reg <= '0;
            olen_reg  <= clen_reg;
            ocons_reg <= ccons_reg;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ocons_reg, olen_reg, obyte_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    // a suppressed segment always marks the record failed
    a_supp_err: assert property (@(posedge aclk) disable iff (!aresetn)
        supp_reg |-> err_reg)
        else $error("suppress set without error flag");

    // a closing result is always the last of its request
    a_close_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && okind_reg != KIND_DATA |-> olast_reg)
        else $error("closing result without last");

    // closing a record restarts the consumed count
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && job_close |=> bcnt_reg == '0 && phase_reg == PH_CTRL)
        else $error("record state not cleared on close");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for scb_record_decoder, with a scoreboard class that predicts
// the decoded bytes and record closes; depends on scbd_pkg and scb_record_decoder

module tb;
    import scbd_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [LEN_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               m_tlast;

    // one expected result of the decoder
    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  cons;
        logic              last;
    } dec_result_t;

    // predicts decoder output per request and checks results in order
    class record_scoreboard;
        dec_result_t      expected_q[$];
        int               fails;
        logic [LEN_W-1:0] limit;
        phase_t           phase;
        logic [SEG_W-1:0] seg_left;
        bit               suppress;
        bit               failed;
        logic [ACC_W-1:0] out_len;
        logic [LEN_W-1:0] in_count;

        function new();
            fails = 0;
            limit = LIMIT_RESET;
            clear_record();
        endfunction

        function void clear_record();
            phase    = PH_CTRL;
            seg_left = '0;
            suppress = 1'b0;
            failed   = 1'b0;
            out_len  = '0;
            in_count = '0;
        endfunction

        function void push_result(kind_t kind, logic [BYTE_W-1:0] data,
                                  logic [LEN_W-1:0] len, logic [LEN_W-1:0] cons);
            dec_result_t r;
            r.kind = kind;
            r.data = data;
            r.len  = len;
            r.cons = cons;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        // closing result, then a fresh record
        function void push_close(bit ok);
            logic [LEN_W-1:0] len;
            len = (out_len > ACC_W'(LEN_SAT)) ? LEN_SAT : out_len[LEN_W-1:0];
            push_result(ok ? KIND_DONE : KIND_FAIL, '0, len, in_count);
            clear_record();
        endfunction

        // running length, saturating, with the over-limit flag
        function void add_length(int unsigned n);
            logic [ACC_W:0] sum;
            sum = {1'b0, out_len} + (ACC_W+1)'(n);
            out_len = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
            suppress = out_len > limit;
            if (suppress)
                failed = 1'b1;
        endfunction

        function void note_request(logic [BYTE_W-1:0] b, logic fin);
            int          first;
            bit          closed;
            int unsigned n;
            logic [3:0]  nib;
            first  = expected_q.size();
            closed = 1'b0;
            nib    = b[7:4];
            if (in_count != LEN_SAT)
                in_count++;

            if (phase == PH_REPEAT) begin
                if (!suppress)
                    repeat (seg_left) push_result(KIND_DATA, b, '0, '0);
                phase    = PH_CTRL;
                seg_left = '0;
            end else if (phase == PH_COPY) begin
                if (!suppress)
                    push_result(KIND_DATA, b, '0, '0);
                seg_left = seg_left - 1'b1;
                if (seg_left == '0)
                    phase = PH_CTRL;
            end else if (nib == NIB_END) begin
                push_close(!failed);
                closed = 1'b1;
            end else if (nib == NIB_ABORT) begin
                push_close(1'b0);
                closed = 1'b1;
            end else if (nib == NIB_BLANK_LO || nib == NIB_BLANK_HI) begin
                n = 32'(b[4:0]);
                add_length(n);
                if (!suppress)
                    repeat (n) push_result(KIND_DATA, BLANK_CHAR, '0, '0);
            end else if (nib == NIB_REPEAT_LO || nib == NIB_REPEAT_HI) begin
                n = 32'(b[4:0]);
                add_length(n);
                seg_left = SEG_W'(n);
                phase    = PH_REPEAT;
            end else if (nib >= NIB_COPY_LO && nib <= NIB_COPY_HI) begin
                n = 32'(b[5:0]);
                add_length(n);
                seg_left = SEG_W'(n);
                phase    = (n != 0) ? PH_COPY : PH_CTRL;
            end

            // input ran out before the record closed
            if (fin && !closed)
                push_close(1'b0);

            if (expected_q.size() > first)
                expected_q[expected_q.size()-1].last = 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] tdata, logic [KIND_W-1:0] tuser,
                                   logic tlast);
            dec_result_t want;
            if (expected_q.size() == 0) begin
                $error("result with none expected: kind %0d data 0x%0h", tuser, tdata);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(tuser));
            compare_field("out_byte", 32'(want.data), 32'(tdata[7:0]));
            compare_field("rec_length", 32'(want.len), 32'(tdata[23:8]));
            compare_field("consumed", 32'(want.cons), 32'(tdata[39:24]));
            compare_field("last", 32'(want.last), 32'(tlast));
        endfunction
    endclass

    record_scoreboard scb;
    bit               tx_quiet;
    bit               rx_quiet;
    int               rx_hold;
    int               items_taken;

    scb_record_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                repeat (rx_hold) @(negedge aclk);
                rx_hold = 0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            scb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // one request on the input side; called and returns at a falling edge
    task automatic send_request(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scb.note_request(b, fin);
        items_taken++;
        @(negedge aclk);
    endtask

    // wait until every expected result is in and the block has gone quiet
    task automatic drain();
        s_tvalid = 1'b0;
        while (scb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_limit(input logic [LEN_W-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        scb.limit = value;
    endtask

    // mostly well-formed record with random content, some noise and early ends
    task automatic random_record();
        logic [BYTE_W-1:0] rec[$];
        int                segs;
        int                pick;
        int unsigned       n;
        logic [3:0]        nib;
        bit                end_fin;
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
                rec.push_back({NIB_BLANK_LO[3:1], n[4:0]});
            end else if (pick <= 4) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
                rec.push_back({NIB_REPEAT_LO[3:1], n[4:0]});
                rec.push_back(BYTE_W'($urandom));
            end else if (pick <= 7) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
                rec.push_back({NIB_COPY_LO[3:2], n[5:0]});
                repeat (n) rec.push_back(BYTE_W'($urandom));
            end else if (pick == 8) begin
                // high nibble with no defined action
                nib = 4'($urandom_range(1, 3) + ($urandom_range(0, 1) ? 4 : 0));
                rec.push_back({nib, 4'($urandom)});
            end else begin
                rec.push_back(BYTE_W'($urandom));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            rec.push_back({NIB_END, 4'($urandom)});
        else if (pick == 7)
            rec.push_back({NIB_ABORT, 4'($urandom)});
        end_fin = ($urandom_range(0, 4) == 0);
        foreach (rec[i])
            send_request(rec[i], ($urandom_range(0, 39) == 0) ||
                                 (i == rec.size() - 1 && end_fin));
    endtask

    task automatic random_phase(input int count);
        int start;
        start = items_taken;
        while (items_taken - start < count) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = tx_quiet;
            random_record();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // main sequence
    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rx_hold     = 0;
        items_taken = 0;
        scb         = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every control class at the reset limit
        send_request({NIB_BLANK_LO, 4'h5}, 1'b0);
        send_request({NIB_REPEAT_LO, 4'h3}, 1'b0);
        send_request(8'h7E, 1'b0);
        send_request({NIB_COPY_LO, 4'h2}, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h2A, 1'b0);
        // zero counts; a zero repeat still eats its byte
        send_request({NIB_BLANK_LO, 4'h0}, 1'b0);
        send_request({NIB_REPEAT_LO, 4'h0}, 1'b0);
        send_request(8'h55, 1'b0);
        send_request({NIB_COPY_LO, 4'h0}, 1'b0);
        send_request({NIB_END, 4'hF}, 1'b0);
        // largest blank and repeat counts, then abort
        send_request({NIB_BLANK_HI, 4'hF}, 1'b0);
        send_request({NIB_REPEAT_HI, 4'hF}, 1'b0);
        send_request(8'hA5, 1'b0);
        send_request({NIB_ABORT, 4'hC}, 1'b0);
        // input ending early, in a segment, on a close and on an ignored byte
        send_request({NIB_BLANK_LO, 4'h1}, 1'b1);
        send_request({NIB_COPY_LO, 4'h3}, 1'b0);
        send_request(8'h11, 1'b1);
        send_request({NIB_END, 4'h0}, 1'b1);
        send_request(8'h6B, 1'b1);
        send_request({NIB_ABORT, 4'h1}, 1'b1);

        // length right at the limit, then over it, then end while failed
        set_limit(16'd3);
        send_request({NIB_BLANK_LO, 4'h3}, 1'b0);
        send_request({NIB_BLANK_LO, 4'h1}, 1'b0);
        send_request({NIB_COPY_LO, 4'h1}, 1'b0);
        send_request(8'h33, 1'b0);
        send_request({NIB_END, 4'h0}, 1'b0);

        // zero limit: every segment suppressed, record fails
        set_limit(16'd0);
        tx_quiet = 1'b1;
        repeat (4) send_request({NIB_BLANK_HI, 4'hF}, 1'b0);
        send_request({NIB_END, 4'h0}, 1'b0);
        tx_quiet = 1'b0;

        // random records; the first phase starts with a long output stall
        set_limit(LEN_SAT);
        rx_hold = 300;
        random_phase(33);
        set_limit(LEN_W'($urandom_range(8, 60)));
        random_phase(33);
        set_limit(LEN_W'($urandom_range(0, 300)));
        random_phase(33);

        drain();
        if (scb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
